FILE: hdl/gmdc_pkg.sv
// ----------------------------------------------------------------------------
// gmdc_pkg
// Shared constants, codes and types of the grid maze carver.
// ----------------------------------------------------------------------------
`default_nettype none

package gmdc_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int CELL_W  = COL_W + ROW_W;
  localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
  localparam int DEPTH_W = $clog2(CELLS + 1);

  localparam int DIM_W    = 7;
  localparam int RAND_W   = 16;
  localparam int STATUS_W = 3;
  localparam int COORD_W  = 6;
  localparam int DIR_W    = 2;

  localparam int CRD_MAX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W     = (CRD_MAX_W + 1 > DIM_W) ? CRD_MAX_W + 1 : DIM_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] GRID_WIDTH_RESET  = 7'd8;
  localparam logic [DIM_W-1:0] GRID_HEIGHT_RESET = 7'd8;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_STARTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CARVED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DEAD     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SIZE     = 3'd5;

  localparam logic [1:0] RUN_IDLE  = 2'd0;
  localparam logic [1:0] RUN_BUSY  = 2'd1;
  localparam logic [1:0] RUN_DONE  = 2'd2;
  localparam logic [1:0] RUN_ERROR = 2'd3;

  localparam logic [DIR_W-1:0] DIR_LEFT   = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_TOP    = 2'd2;
  localparam logic [DIR_W-1:0] DIR_BOTTOM = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0] grid_width;
    logic [DIM_W-1:0] grid_height;
  } cfg_t;

  typedef struct packed {
    logic                 rd0_en;
    logic [ROW_W-1:0]     rd0_row;
    logic                 rd1_en;
    logic [ROW_W-1:0]     rd1_row;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_row;
    logic [MAX_WIDTH-1:0] wr_data;
    logic                 clear;
  } vm_req_t;

endpackage

`default_nettype wire

FILE: hdl/gmdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// gmdc_cfg_regs
// Register port holding the grid width and height.
// ----------------------------------------------------------------------------
`default_nettype none

module gmdc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [gmdc_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [gmdc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [gmdc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output gmdc_pkg::cfg_t                       cfg
);
  import gmdc_pkg::*;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic             wr_beat;
  logic [CFG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_beat = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_beat) begin
      unique case (reg_idx)
        REG_GRID_WIDTH:  cfg_nxt.grid_width  = pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT: cfg_nxt.grid_height = pwdata[DIM_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_WIDTH:  prdata = CFG_DATA_W'(cfg_r.grid_width);
      REG_GRID_HEIGHT: prdata = CFG_DATA_W'(cfg_r.grid_height);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width  <= GRID_WIDTH_RESET;
      cfg_r.grid_height <= GRID_HEIGHT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: hdl/gmdc_mod_unit.sv
// ----------------------------------------------------------------------------
// gmdc_mod_unit
// Two-lane restoring remainder unit, one dividend bit per cycle per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module gmdc_mod_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [gmdc_pkg::RAND_W-1:0]  dividend_a,
  input  wire logic [gmdc_pkg::RAND_W-1:0]  dividend_b,
  input  wire logic [gmdc_pkg::DIM_W-1:0]   divisor_a,
  input  wire logic [gmdc_pkg::DIM_W-1:0]   divisor_b,
  output logic                              done,
  output logic      [gmdc_pkg::DIM_W-1:0]   rem_a,
  output logic      [gmdc_pkg::DIM_W-1:0]   rem_b
);
  import gmdc_pkg::*;

  localparam int CNT_W = $clog2(RAND_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RAND_W-1:0] sh_a_r, sh_a_nxt, sh_b_r, sh_b_nxt;
  logic [DIM_W-1:0]  div_a_r, div_a_nxt, div_b_r, div_b_nxt;
  logic [DIM_W-1:0]  rem_a_r, rem_a_nxt, rem_b_r, rem_b_nxt;

  function automatic logic [DIM_W-1:0] rem_step(input logic [DIM_W-1:0] rem,
                                                input logic             bit_in,
                                                input logic [DIM_W-1:0] div);
    logic [DIM_W:0] trial;
    trial = {rem, bit_in};
    if (trial >= {1'b0, div}) begin
      trial = trial - {1'b0, div};
    end
    return trial[DIM_W-1:0];
  endfunction

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    sh_a_nxt  = sh_a_r;
    sh_b_nxt  = sh_b_r;
    div_a_nxt = div_a_r;
    div_b_nxt = div_b_r;
    rem_a_nxt = rem_a_r;
    rem_b_nxt = rem_b_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      sh_a_nxt  = dividend_a;
      sh_b_nxt  = dividend_b;
      div_a_nxt = divisor_a;
      div_b_nxt = divisor_b;
      rem_a_nxt = '0;
      rem_b_nxt = '0;
    end else if (busy_r) begin
      rem_a_nxt = rem_step(rem_a_r, sh_a_r[RAND_W-1], div_a_r);
      rem_b_nxt = rem_step(rem_b_r, sh_b_r[RAND_W-1], div_b_r);
      sh_a_nxt  = {sh_a_r[RAND_W-2:0], 1'b0};
      sh_b_nxt  = {sh_b_r[RAND_W-2:0], 1'b0};
      cnt_nxt   = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(RAND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_a_r  <= sh_a_nxt;
    sh_b_r  <= sh_b_nxt;
    div_a_r <= div_a_nxt;
    div_b_r <= div_b_nxt;
    rem_a_r <= rem_a_nxt;
    rem_b_r <= rem_b_nxt;
  end

  assign done  = done_r;
  assign rem_a = rem_a_r;
  assign rem_b = rem_b_r;

endmodule

`default_nettype wire

FILE: hdl/gmdc_visit_map.sv
// ----------------------------------------------------------------------------
// gmdc_visit_map
// Visited map held as one row of cells per memory word, with a valid bit per
// row so that a new maze clears the whole map at once.
// ----------------------------------------------------------------------------
`default_nettype none

module gmdc_visit_map (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire gmdc_pkg::vm_req_t               req,
  output logic      [gmdc_pkg::MAX_WIDTH-1:0]  rdata0,
  output logic      [gmdc_pkg::MAX_WIDTH-1:0]  rdata1
);
  import gmdc_pkg::*;

  logic [MAX_WIDTH-1:0]  mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_valid_r, row_valid_nxt;
  logic [MAX_WIDTH-1:0]  rdata0_r, rdata1_r;
  logic                  rd0_valid_r, rd1_valid_r;

  always_comb begin
    row_valid_nxt = req.clear ? '0 : row_valid_r;
    if (req.wr_en) begin
      row_valid_nxt[req.wr_row] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else begin
      row_valid_r <= row_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
    if (req.rd0_en) begin
      rdata0_r    <= mem[req.rd0_row];
      rd0_valid_r <= row_valid_r[req.rd0_row];
    end
    if (req.rd1_en) begin
      rdata1_r    <= mem[req.rd1_row];
      rd1_valid_r <= row_valid_r[req.rd1_row];
    end
  end

  assign rdata0 = rdata0_r & {MAX_WIDTH{rd0_valid_r}};
  assign rdata1 = rdata1_r & {MAX_WIDTH{rd1_valid_r}};

endmodule

`default_nettype wire

FILE: hdl/grid_maze_dfs_carver.sv
// ----------------------------------------------------------------------------
// grid_maze_dfs_carver
// Randomised depth-first maze carver, one search step per input beat.
//
//   Channel  Direction  Contents
//   in_      slave      tdata: rand_a, rand_b   tuser: func
//   out_     master     tdata: cell_x, cell_y, carved_dir, next_x, next_y
//                       tuser: status
//   cfg_     APB slave  grid_width at 0x0, grid_height at 0x4
//
// A search step passes through the stack read, the visited-row reads on the
// map's two read ports and the carve before its result is registered. A
// start gives its result once the remainder unit has reduced both random
// values by the grid size. Steps outside a run, a finished run and a size
// error are answered from the idle state. Reset clears the row valid
// bits of the visited map at once, so no clearing pass is needed. A result
// that is not taken waits in the output register while the next beat is
// processed; a further result waits in a holding register and stalls the
// input until the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_maze_dfs_carver (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [15:0] rand_a, [31:16] rand_b
  input  wire logic [31:0]                     in_tdata,
  // [0] func
  input  wire logic [0:0]                      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [5:0] cell_x, [11:6] cell_y, [13:12] carved_dir, [19:14] next_x,
  // [25:20] next_y, [31:26] zero
  output logic      [31:0]                     out_tdata,
  // [2:0] status
  output logic      [2:0]                      out_tuser,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [gmdc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [gmdc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [gmdc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);
  import gmdc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ROWS = 3'd2;
  localparam logic [2:0] S_ROW2 = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  localparam int FIELDS_W = 4 * COORD_W + DIR_W;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;
    logic [DIR_W-1:0]    dir;
    logic [COORD_W-1:0]  next_x;
    logic [COORD_W-1:0]  next_y;
  } res_t;

  cfg_t    cfg;
  vm_req_t vm_req;
  logic [MAX_WIDTH-1:0] vm_rdata0, vm_rdata1;
  logic                 mod_start, mod_done;
  logic [DIM_W-1:0]     mod_rem_a, mod_rem_b;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          run_r, run_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [RAND_W-1:0]   ra_r, ra_nxt;
  logic [1:0]          mod3_r, mod3_nxt;
  logic [COL_W-1:0]    cx_r, cx_nxt;
  logic [ROW_W-1:0]    cy_r, cy_nxt;
  logic [MAX_WIDTH-1:0] top_row_r, top_row_nxt;
  res_t                res_r, res_nxt;
  res_t                out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [CELL_W-1:0]   stack_mem [CELLS];
  logic [CELL_W-1:0]   stk_rdata_r;
  logic [CELL_W-1:0]   stk_raddr, stk_waddr, stk_wdata;
  logic                stk_we;

  logic                acc, slot_free, do_emit, size_bad;
  res_t                emit_res;
  logic [DEPTH_W-1:0]  depth_m1, depth_p1;
  logic [COL_W-1:0]    cxm1, sx;
  logic [ROW_W-1:0]    cym1, sy, st_cy;
  logic [CMP_W-1:0]    cxp1_c, cyp1_c, w_c, h_c;
  logic                x_in, y_in;
  logic [3:0]          cand;
  logic [2:0]          n_cand;
  logic [1:0]          pick;
  logic [DIR_W-1:0]    dir;
  logic [COL_W-1:0]    nx;
  logic [ROW_W-1:0]    ny;
  logic [MAX_WIDTH-1:0] base_row;

  function automatic logic [1:0] mod3_of(input logic [RAND_W-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    logic [1:0] r;
    s = '0;
    for (int i = 0; i < RAND_W / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    unique case (t)
      3'd0, 3'd3, 3'd6: r = 2'd0;
      3'd1, 3'd4, 3'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [DIR_W-1:0] nth_set(input logic [3:0] m, input logic [1:0] p);
    logic [1:0]       cnt;
    logic             found;
    logic [DIR_W-1:0] d;
    cnt   = '0;
    found = 1'b0;
    d     = DIR_LEFT;
    for (int k = 0; k < 4; k++) begin
      if (m[k] && !found) begin
        if (cnt == p) begin
          d     = DIR_W'(k);
          found = 1'b1;
        end
        cnt = cnt + 2'd1;
      end
    end
    return d;
  endfunction

  gmdc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  gmdc_mod_unit u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mod_start),
    .dividend_a (in_tdata[RAND_W-1:0]),
    .dividend_b (in_tdata[2*RAND_W-1:RAND_W]),
    .divisor_a  (cfg.grid_width),
    .divisor_b  (cfg.grid_height),
    .done       (mod_done),
    .rem_a      (mod_rem_a),
    .rem_b      (mod_rem_b)
  );

  gmdc_visit_map u_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (vm_req),
    .rdata0 (vm_rdata0),
    .rdata1 (vm_rdata1)
  );

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign depth_m1  = depth_r - DEPTH_W'(1);
  assign depth_p1  = depth_r + DEPTH_W'(1);
  assign stk_raddr = depth_m1[CELL_W-1:0];

  assign w_c      = CMP_W'(cfg.grid_width);
  assign h_c      = CMP_W'(cfg.grid_height);
  assign size_bad = (cfg.grid_width == '0) || (cfg.grid_height == '0) ||
                    (w_c > CMP_W'(MAX_WIDTH)) || (h_c > CMP_W'(MAX_HEIGHT));

  assign sx    = mod_rem_a[COL_W-1:0];
  assign sy    = mod_rem_b[ROW_W-1:0];
  assign st_cy = stk_rdata_r[CELL_W-1:COL_W];

  // Neighbour tests against the rows in hand: vm_rdata1 is the current row,
  // vm_rdata0 the row below and top_row_r the row above.
  always_comb begin
    cxm1   = cx_r - COL_W'(1);
    cym1   = cy_r - ROW_W'(1);
    cxp1_c = CMP_W'(cx_r) + CMP_W'(1);
    cyp1_c = CMP_W'(cy_r) + CMP_W'(1);
    x_in   = CMP_W'(cx_r) < w_c;
    y_in   = CMP_W'(cy_r) < h_c;
    cand[DIR_LEFT]   = (cx_r != '0) && (CMP_W'(cxm1) < w_c) && y_in && !vm_rdata1[cxm1];
    cand[DIR_RIGHT]  = (cxp1_c < CMP_W'(MAX_WIDTH)) && (cxp1_c < w_c) && y_in &&
                       !vm_rdata1[cxp1_c[COL_W-1:0]];
    cand[DIR_TOP]    = (cy_r != '0) && (CMP_W'(cym1) < h_c) && x_in && !top_row_r[cx_r];
    cand[DIR_BOTTOM] = (cyp1_c < CMP_W'(MAX_HEIGHT)) && (cyp1_c < h_c) && x_in &&
                       !vm_rdata0[cx_r];
    n_cand = 3'($countones(cand));
    unique case (n_cand)
      3'd2:    pick = {1'b0, ra_r[0]};
      3'd3:    pick = mod3_r;
      3'd4:    pick = ra_r[1:0];
      default: pick = 2'd0;
    endcase
    dir = nth_set(cand, pick);
    unique case (dir)
      DIR_LEFT: begin
        nx = cxm1;
        ny = cy_r;
        base_row = vm_rdata1;
      end
      DIR_RIGHT: begin
        nx = cxp1_c[COL_W-1:0];
        ny = cy_r;
        base_row = vm_rdata1;
      end
      DIR_TOP: begin
        nx = cx_r;
        ny = cym1;
        base_row = top_row_r;
      end
      default: begin
        nx = cx_r;
        ny = cyp1_c[ROW_W-1:0];
        base_row = vm_rdata0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    depth_nxt     = depth_r;
    ra_nxt        = ra_r;
    mod3_nxt      = mod3_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    top_row_nxt   = top_row_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    do_emit       = 1'b0;
    emit_res      = '0;
    mod_start     = 1'b0;
    vm_req        = '0;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          ra_nxt = in_tdata[RAND_W-1:0];
          if (in_tuser[0] == FUNC_START) begin
            if (size_bad) begin
              run_nxt         = RUN_ERROR;
              do_emit         = 1'b1;
              emit_res.status = ST_SIZE;
            end else begin
              mod_start = 1'b1;
              state_nxt = S_DIV;
            end
          end else if (run_r != RUN_BUSY) begin
            do_emit         = 1'b1;
            emit_res.status = ST_IDLE;
          end else if (depth_r == '0) begin
            run_nxt         = RUN_DONE;
            do_emit         = 1'b1;
            emit_res.status = ST_FINISHED;
          end else begin
            depth_nxt = depth_m1;
            state_nxt = S_ROWS;
          end
        end
      end
      S_DIV: begin
        if (mod_done) begin
          vm_req.clear       = 1'b1;
          vm_req.wr_en       = 1'b1;
          vm_req.wr_row      = sy;
          vm_req.wr_data     = '0;
          vm_req.wr_data[sx] = 1'b1;
          stk_we             = 1'b1;
          stk_waddr          = '0;
          stk_wdata          = {sy, sx};
          depth_nxt          = DEPTH_W'(1);
          run_nxt            = RUN_BUSY;
          do_emit            = 1'b1;
          emit_res.status    = ST_STARTED;
          emit_res.cell_x    = COORD_W'(sx);
          emit_res.cell_y    = COORD_W'(sy);
        end
      end
      S_ROWS: begin
        cx_nxt         = stk_rdata_r[COL_W-1:0];
        cy_nxt         = st_cy;
        mod3_nxt       = mod3_of(ra_r);
        vm_req.rd0_en  = 1'b1;
        vm_req.rd0_row = st_cy - ROW_W'(1);
        vm_req.rd1_en  = 1'b1;
        vm_req.rd1_row = st_cy;
        state_nxt      = S_ROW2;
      end
      S_ROW2: begin
        top_row_nxt    = vm_rdata0;
        vm_req.rd0_en  = 1'b1;
        vm_req.rd0_row = cy_r + ROW_W'(1);
        state_nxt      = S_EVAL;
      end
      S_EVAL: begin
        do_emit         = 1'b1;
        emit_res.cell_x = COORD_W'(cx_r);
        emit_res.cell_y = COORD_W'(cy_r);
        if (n_cand == 3'd0) begin
          emit_res.status = ST_DEAD;
        end else begin
          vm_req.wr_en       = 1'b1;
          vm_req.wr_row      = ny;
          vm_req.wr_data     = base_row;
          vm_req.wr_data[nx] = 1'b1;
          if (depth_p1 < DEPTH_W'(CELLS)) begin
            stk_we    = 1'b1;
            stk_waddr = depth_p1[CELL_W-1:0];
            stk_wdata = {ny, nx};
            depth_nxt = depth_r + DEPTH_W'(2);
          end else begin
            depth_nxt = depth_p1;
          end
          emit_res.status = ST_CARVED;
          emit_res.dir    = dir;
          emit_res.next_x = COORD_W'(nx);
          emit_res.next_y = COORD_W'(ny);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_emit) begin
      if (slot_free) begin
        out_valid_nxt = 1'b1;
        out_nxt       = emit_res;
        state_nxt     = S_IDLE;
      end else begin
        res_nxt   = emit_res;
        state_nxt = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= RUN_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ra_r      <= ra_nxt;
    mod3_r    <= mod3_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    top_row_r <= top_row_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_r <= stack_mem[stk_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {{(32 - FIELDS_W){1'b0}}, out_r.next_y, out_r.next_x, out_r.dir,
                       out_r.cell_y, out_r.cell_x};

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(CELLS))
    else $error("stack depth beyond capacity");

  a_step_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tuser[0] == FUNC_STEP && run_r == RUN_BUSY && depth_r != '0)
    |=> (state_r == S_ROWS && depth_r == $past(depth_m1)))
    else $error("step beat did not pop the stack");

  a_start_write: assert property (@(posedge clk) disable iff (!rst_n)
    vm_req.clear |-> (vm_req.wr_en && $onehot(vm_req.wr_data) && stk_we &&
                      stk_waddr == '0))
    else $error("map clear without start cell write");

  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == S_DIV)
    else $error("remainder result outside start sequence");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench of the grid maze carver
// Drives start and step beats through the input stream, writes the grid size
// over the register port between phases, and predicts every result beat from
// its own copy of the visited map, the cell stack and the run state. Results
// are checked field by field in order, under random stalls on both streams.
// ----------------------------------------------------------------------------

module testbench;
  import gmdc_pkg::*;

  localparam int BEAT_TARGET = 1650;

  typedef struct packed {
    logic              func;
    logic [RAND_W-1:0] rand_a;
    logic [RAND_W-1:0] rand_b;
  } search_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;
    logic [DIR_W-1:0]    carved_dir;
    logic [COORD_W-1:0]  next_x;
    logic [COORD_W-1:0]  next_y;
  } carve_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic [2:0]            out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  search_beat_t  search_beats [$];
  carve_report_t carve_reports [$];
  int            beats_issued = 0;
  int            failures = 0;
  bit            in_taken = 1'b0;
  bit            calm = 1'b0;

  // Predictor state
  bit                visited [CELLS];
  logic [CELL_W-1:0] cell_stack_m [CELLS];
  int                stack_level = 0;
  logic [1:0]        run_state = RUN_IDLE;
  logic [DIM_W-1:0]  cols = GRID_WIDTH_RESET;
  logic [DIM_W-1:0]  rows = GRID_HEIGHT_RESET;

  grid_maze_dfs_carver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] rand_a, [31:16] rand_b
    .in_tuser   (in_tuser),    // [0] func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [5:0] cell_x, [11:6] cell_y, [13:12] carved_dir,
                               // [19:14] next_x, [25:20] next_y
    .out_tuser  (out_tuser),   // [2:0] status
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #2 clk = ~clk;

  function automatic bit open_cell(int x, int y);
    if (x < 0 || y < 0) return 1'b0;
    if (x >= int'(cols) || x >= MAX_WIDTH) return 1'b0;
    if (y >= int'(rows) || y >= MAX_HEIGHT) return 1'b0;
    return !visited[y * MAX_WIDTH + x];
  endfunction

  function automatic carve_report_t predict_carve(search_beat_t b);
    carve_report_t     r;
    int                sx, sy, cx, cy, nx, ny, n, pick;
    logic [DIR_W-1:0]  cand [4];
    logic [DIR_W-1:0]  dir;
    logic [CELL_W-1:0] cur;
    r = '0;
    if (b.func == FUNC_START) begin
      if (cols == 0 || rows == 0 || cols > MAX_WIDTH || rows > MAX_HEIGHT) begin
        run_state = RUN_ERROR;
        r.status = ST_SIZE;
        return r;
      end
      sx = int'(b.rand_a) % int'(cols);
      sy = int'(b.rand_b) % int'(rows);
      foreach (visited[i]) visited[i] = 1'b0;
      visited[sy * MAX_WIDTH + sx] = 1'b1;
      cell_stack_m[0] = CELL_W'(sy * MAX_WIDTH + sx);
      stack_level = 1;
      run_state = RUN_BUSY;
      r.status = ST_STARTED;
      r.cell_x = COORD_W'(sx);
      r.cell_y = COORD_W'(sy);
      return r;
    end
    if (run_state != RUN_BUSY) begin
      r.status = ST_IDLE;
      return r;
    end
    if (stack_level == 0) begin
      run_state = RUN_DONE;
      r.status = ST_FINISHED;
      return r;
    end
    stack_level--;
    cur = cell_stack_m[stack_level];
    cx = int'(cur) % MAX_WIDTH;
    cy = int'(cur) / MAX_WIDTH;
    r.cell_x = COORD_W'(cx);
    r.cell_y = COORD_W'(cy);
    n = 0;
    if (open_cell(cx - 1, cy)) begin cand[n] = DIR_LEFT;   n++; end
    if (open_cell(cx + 1, cy)) begin cand[n] = DIR_RIGHT;  n++; end
    if (open_cell(cx, cy - 1)) begin cand[n] = DIR_TOP;    n++; end
    if (open_cell(cx, cy + 1)) begin cand[n] = DIR_BOTTOM; n++; end
    if (n == 0) begin
      r.status = ST_DEAD;
      return r;
    end
    pick = int'(b.rand_a) % n;
    dir = cand[pick];
    nx = cx;
    ny = cy;
    case (dir)
      DIR_LEFT:   nx = cx - 1;
      DIR_RIGHT:  nx = cx + 1;
      DIR_TOP:    ny = cy - 1;
      default:    ny = cy + 1;
    endcase
    cell_stack_m[stack_level] = cur;
    stack_level++;
    visited[ny * MAX_WIDTH + nx] = 1'b1;
    if (stack_level < CELLS) begin
      cell_stack_m[stack_level] = CELL_W'(ny * MAX_WIDTH + nx);
      stack_level++;
    end
    r.status = ST_CARVED;
    r.carved_dir = dir;
    r.next_x = COORD_W'(nx);
    r.next_y = COORD_W'(ny);
    return r;
  endfunction

  // Input acceptance and prediction
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      carve_reports = {carve_reports,
                       predict_carve({in_tuser[0], in_tdata[15:0], in_tdata[31:16]})};
    end
  end

  // Driver
  always @(negedge clk) begin
    search_beat_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (search_beats.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
        b = search_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= b.func;
        in_tdata <= {b.rand_b, b.rand_a};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && (calm || $urandom_range(99) >= 30);
  end

  // Monitor
  always @(posedge clk) begin
    carve_report_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (carve_reports.size() == 0) begin
        $error("result beat with no expectation: status %0d tdata %h", out_tuser, out_tdata);
        failures++;
      end else begin
        e = carve_reports.pop_front();
        if (out_tuser != e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_tuser);
          failures++;
        end
        if (out_tdata[5:0] != e.cell_x) begin
          $error("cell_x: expected %0d, actual %0d", e.cell_x, out_tdata[5:0]);
          failures++;
        end
        if (out_tdata[11:6] != e.cell_y) begin
          $error("cell_y: expected %0d, actual %0d", e.cell_y, out_tdata[11:6]);
          failures++;
        end
        if (out_tdata[13:12] != e.carved_dir) begin
          $error("carved_dir: expected %0d, actual %0d", e.carved_dir, out_tdata[13:12]);
          failures++;
        end
        if (out_tdata[19:14] != e.next_x) begin
          $error("next_x: expected %0d, actual %0d", e.next_x, out_tdata[19:14]);
          failures++;
        end
        if (out_tdata[25:20] != e.next_y) begin
          $error("next_y: expected %0d, actual %0d", e.next_y, out_tdata[25:20]);
          failures++;
        end
      end
    end
  end

  task automatic add_beat(logic func, logic [RAND_W-1:0] ra, logic [RAND_W-1:0] rb);
    search_beat_t b;
    b = {func, ra, rb};
    search_beats = {search_beats, b};
    beats_issued++;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (search_beats.size() != 0 || in_tvalid || carve_reports.size() != 0);
  endtask

  // Write one register, then read it back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] want;
    want = CFG_DATA_W'(value[DIM_W-1:0]);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (idx == REG_GRID_WIDTH) cols = value[DIM_W-1:0];
    else rows = value[DIM_W-1:0];
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== want) begin
      $error("%s readback: expected %0d, actual %0d",
             (idx == REG_GRID_WIDTH) ? "grid_width" : "grid_height", want, cfg_prdata);
      failures++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_grid(int w, int h);
    wait_drained();
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'({$urandom, 7'd0}) | CFG_DATA_W'(w));
    write_reg(REG_GRID_HEIGHT, CFG_DATA_W'({$urandom, 7'd0}) | CFG_DATA_W'(h));
  endtask

  initial begin
    int phase, sel, w, h, steps;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size of 8 by 8
    add_beat(FUNC_STEP, 16'h0000, 16'h0000);
    add_beat(FUNC_START, 16'hFFFF, 16'hFFFF);
    add_beat(FUNC_STEP, 16'h0000, 16'hFFFF);
    add_beat(FUNC_STEP, 16'hFFFF, 16'h0000);
    add_beat(FUNC_STEP, 16'h0000, 16'h0000);
    add_beat(FUNC_STEP, 16'h0001, 16'hFFFF);
    add_beat(FUNC_START, 16'h0000, 16'h0000);
    add_beat(FUNC_STEP, 16'hFFFF, 16'hFFFF);
    add_beat(FUNC_STEP, 16'h0000, 16'h0000);
    set_grid(MAX_WIDTH, MAX_HEIGHT);
    add_beat(FUNC_START, 16'hFFFF, 16'hFFFF);
    add_beat(FUNC_STEP, 16'hFFFF, 16'h0000);
    add_beat(FUNC_STEP, 16'h0002, 16'h0000);
    set_grid(1, 1);
    add_beat(FUNC_START, 16'h1234, 16'h5678);
    add_beat(FUNC_STEP, 16'h0000, 16'h0000);
    add_beat(FUNC_STEP, 16'h0000, 16'h0000);
    add_beat(FUNC_STEP, 16'h0000, 16'h0000);
    set_grid(0, 8);
    add_beat(FUNC_START, 16'h0003, 16'h0003);
    add_beat(FUNC_STEP, 16'h0003, 16'h0003);
    set_grid(MAX_WIDTH + 1, 127);
    add_beat(FUNC_START, 16'h0003, 16'h0003);
    set_grid(2, 1);
    add_beat(FUNC_START, 16'h0001, 16'h0000);
    add_beat(FUNC_STEP, 16'h0000, 16'h0000);
    add_beat(FUNC_STEP, 16'h0000, 16'h0000);
    add_beat(FUNC_STEP, 16'h0000, 16'h0000);
    add_beat(FUNC_STEP, 16'h0000, 16'h0000);

    phase = 0;
    while (beats_issued < BEAT_TARGET) begin
      phase++;
      sel = $urandom_range(99);
      if (sel < 60) begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
      end else if (sel < 70) begin
        w = ($urandom_range(1)) ? $urandom_range(1, 2) : $urandom_range(MAX_WIDTH - 1, MAX_WIDTH);
        h = ($urandom_range(1)) ? $urandom_range(1, 2) : $urandom_range(MAX_HEIGHT - 1, MAX_HEIGHT);
      end else if (sel < 80) begin
        w = $urandom_range(9, MAX_WIDTH);
        h = $urandom_range(9, MAX_HEIGHT);
      end else if (sel < 88) begin
        w = ($urandom_range(1)) ? 0 : $urandom_range(MAX_WIDTH + 1, 127);
        h = $urandom_range(0, 127);
        if ($urandom_range(1)) begin
          h = w;
          w = $urandom_range(1, MAX_WIDTH);
        end
      end else begin
        w = MAX_WIDTH;
        h = MAX_HEIGHT;
      end
      set_grid(w, h);
      calm = (phase >= 3 && phase <= 6);
      if (w == 0 || h == 0 || w > MAX_WIDTH || h > MAX_HEIGHT) steps = $urandom_range(1, 5);
      else if (w * h <= 64) steps = 2 * w * h + $urandom_range(0, 3);
      else steps = $urandom_range(40, 160);
      // Most phases begin a new maze; the rest carry on the previous run at the new size.
      if ($urandom_range(99) < 85) add_beat(FUNC_START, RAND_W'($urandom), RAND_W'($urandom));
      repeat (steps) begin
        if ($urandom_range(99) < 8) begin
          add_beat(1'($urandom_range(1)), RAND_W'($urandom), RAND_W'($urandom));
        end else begin
          add_beat(FUNC_STEP, RAND_W'($urandom), RAND_W'($urandom));
        end
      end
    end

    wait_drained();
    calm = 1'b0;
    repeat (24) @(posedge clk);
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
